// ===== sv/lav_pkg.sv =====
package lav_pkg;

    localparam int OUT_FRAC_BITS = 30;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = OUT_FRAC_BITS + 1;
    localparam int NUM_W      = OUT_FRAC_BITS + 32;
    localparam int NORM_LAT   = 8 + SQRT_STEPS + DIV_STEPS;
    localparam int TOP_LAT    = 3 * NORM_LAT + 5;

    typedef logic signed [31:0] s32_t;
    typedef logic signed [63:0] s64_t;
    typedef s32_t [2:0] vec32_t;
    typedef s64_t [2:0] vec64_t;

    localparam s32_t S32_MIN = 32'sh8000_0000;
    localparam s32_t S32_MAX = 32'sh7fff_ffff;

    localparam int NORM_ONE_I = 1 << OUT_FRAC_BITS;
    localparam s32_t NORM_ONE = s32_t'(NORM_ONE_I);
    localparam logic [DIV_STEPS-1:0] ONE_Q = DIV_STEPS'(NORM_ONE_I);

    typedef struct packed {
        s32_t eye_x;
        s32_t eye_y;
        s32_t eye_z;
        s32_t target_x;
        s32_t target_y;
        s32_t target_z;
        s32_t up_x;
        s32_t up_y;
        s32_t up_z;
    } lav_in_t;

    typedef struct packed {
        s32_t side_x;
        s32_t side_y;
        s32_t side_z;
        s32_t trueup_x;
        s32_t trueup_y;
        s32_t trueup_z;
        s32_t forward_x;
        s32_t forward_y;
        s32_t forward_z;
        s32_t shift_x;
        s32_t shift_y;
        s32_t shift_z;
    } lav_out_t;

    typedef struct packed {
        logic [63:0]      s;
        logic [35:0]      rem;
        logic [31:0]      root;
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } lav_sq_t;

    typedef struct packed {
        logic [31:0]                den;
        logic [2:0][NUM_W-1:0]      num;
        logic [2:0][32:0]           rem;
        logic [2:0][DIV_STEPS-1:0]  quo;
        logic [2:0]                 neg;
        logic                       zero;
    } lav_dv_t;

endpackage

// ===== sv/lav_norm.sv =====
module lav_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  lav_pkg::vec64_t v,
    output logic            out_valid,
    output lav_pkg::vec32_t r
);
    import lav_pkg::*;

    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic [2:0][63:0] m1_reg, m2_reg, m3_reg;
    logic [2:0]       n1_reg, n2_reg, n3_reg, n4_reg, n5_reg, n6_reg;
    logic [63:0]      or1_reg;
    logic [7:0]       nz2_reg;
    logic [7:0][2:0]  lz2_reg;
    logic [5:0]       lz3_reg;
    logic             z3_reg, z4_reg, z5_reg, z6_reg;
    logic [2:0][30:0] sh4_reg, sh5_reg, sh6_reg;
    logic [2:0][61:0] sq5_reg;
    logic [63:0]      s6_reg;

    logic [2:0][63:0] m1_next;
    logic [2:0]       n1_next;
    logic [7:0]       nz2_next;
    logic [7:0][2:0]  lz2_next;
    logic [5:0]       lz3_next;
    logic [2:0][30:0] sh4_next;
    logic [2:0][61:0] sq5_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_next[i] = v[i][63];
            m1_next[i] = v[i][63] ? 64'(-v[i]) : 64'(v[i]);
        end
    end

    always_comb
    begin
        logic [7:0] grp;
        logic       hit;
        for (int g = 0; g < 8; g++)
        begin
            grp = or1_reg[8*g +: 8];
            nz2_next[g] = |grp;
            lz2_next[g] = 3'd0;
            hit = 1'b0;
            for (int b = 7; b >= 0; b--)
            begin
                if (!hit && grp[b])
                begin
                    lz2_next[g] = 3'(7 - b);
                    hit = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        logic hit;
        lz3_next = 6'd0;
        hit = 1'b0;
        for (int g = 7; g >= 0; g--)
        begin
            if (!hit && nz2_reg[g])
            begin
                lz3_next = {3'(7 - g), lz2_reg[g]};
                hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [63:0] t;
        for (int i = 0; i < 3; i++)
        begin
            t = m3_reg[i] << lz3_reg;
            sh4_next[i] = t[63:33];
            sq5_next[i] = sh4_reg[i] * sh4_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg  <= m1_next;
        n1_reg  <= n1_next;
        or1_reg <= m1_next[0] | m1_next[1] | m1_next[2];
        m2_reg  <= m1_reg;
        n2_reg  <= n1_reg;
        nz2_reg <= nz2_next;
        lz2_reg <= lz2_next;
        m3_reg  <= m2_reg;
        n3_reg  <= n2_reg;
        lz3_reg <= lz3_next;
        z3_reg  <= ~|nz2_reg;
        sh4_reg <= sh4_next;
        n4_reg  <= n3_reg;
        z4_reg  <= z3_reg;
        sq5_reg <= sq5_next;
        sh5_reg <= sh4_reg;
        n5_reg  <= n4_reg;
        z5_reg  <= z4_reg;
        s6_reg  <= 64'(sq5_reg[0]) + 64'(sq5_reg[1]) + 64'(sq5_reg[2]);
        sh6_reg <= sh5_reg;
        n6_reg  <= n5_reg;
        z6_reg  <= z5_reg;
    end

    lav_sq_t                sq_reg  [SQRT_STEPS];
    lav_sq_t                sq_next [SQRT_STEPS];
    logic [SQRT_STEPS-1:0]  sq_vld_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int P = 2 * (SQRT_STEPS - 1 - k);
        lav_sq_t cur;
        if (k == 0)
        begin : g_first
            always_comb
            begin
                cur      = '0;
                cur.s    = s6_reg;
                cur.mag  = sh6_reg;
                cur.neg  = n6_reg;
                cur.zero = z6_reg;
            end
        end
        else
        begin : g_rest
            assign cur = sq_reg[k-1];
        end

        always_comb
        begin
            logic [35:0] rem_sh;
            logic [35:0] trial;
            rem_sh = {cur.rem[33:0], cur.s[P+1:P]};
            trial  = {2'b00, cur.root, 2'b01};
            sq_next[k] = cur;
            if (rem_sh >= trial)
            begin
                sq_next[k].rem  = rem_sh - trial;
                sq_next[k].root = {cur.root[30:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem  = rem_sh;
                sq_next[k].root = {cur.root[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg <= '0;
        else
            sq_vld_reg <= {sq_vld_reg[SQRT_STEPS-2:0], v6_reg};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
            sq_reg[k] <= sq_next[k];
    end

    lav_dv_t pr_reg, pr_next;
    logic    pr_vld_reg;

    always_comb
    begin
        lav_sq_t t;
        t = sq_reg[SQRT_STEPS-1];
        pr_next      = '0;
        pr_next.den  = t.root;
        pr_next.neg  = t.neg;
        pr_next.zero = t.zero;
        for (int i = 0; i < 3; i++)
        begin
            pr_next.num[i] = {1'b0, t.mag[i], {OUT_FRAC_BITS{1'b0}}}
                             + NUM_W'(t.root[31:1]);
            pr_next.rem[i] = {2'b00, pr_next.num[i][NUM_W-1:OUT_FRAC_BITS+1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_vld_reg <= 1'b0;
        else
            pr_vld_reg <= sq_vld_reg[SQRT_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        pr_reg <= pr_next;
    end

    lav_dv_t               dv_reg  [DIV_STEPS];
    lav_dv_t               dv_next [DIV_STEPS];
    logic [DIV_STEPS-1:0]  dv_vld_reg;

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int B = OUT_FRAC_BITS - j;
        lav_dv_t cur;
        if (j == 0)
        begin : g_first
            assign cur = pr_reg;
        end
        else
        begin : g_rest
            assign cur = dv_reg[j-1];
        end

        always_comb
        begin
            logic [32:0] r_sh;
            dv_next[j] = cur;
            for (int i = 0; i < 3; i++)
            begin
                r_sh = {cur.rem[i][31:0], cur.num[i][B]};
                if (r_sh >= {1'b0, cur.den})
                begin
                    dv_next[j].rem[i] = r_sh - {1'b0, cur.den};
                    dv_next[j].quo[i] = {cur.quo[i][DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    dv_next[j].rem[i] = r_sh;
                    dv_next[j].quo[i] = {cur.quo[i][DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg <= '0;
        else
            dv_vld_reg <= {dv_vld_reg[DIV_STEPS-2:0], pr_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STEPS; j++)
            dv_reg[j] <= dv_next[j];
    end

    vec32_t r_reg, r_next;
    logic   out_vld_reg;

    always_comb
    begin
        lav_dv_t              t;
        logic [DIV_STEPS-1:0] q;
        logic [31:0]          m32;
        t = dv_reg[DIV_STEPS-1];
        for (int i = 0; i < 3; i++)
        begin
            q   = (t.quo[i] > ONE_Q) ? ONE_Q : t.quo[i];
            m32 = 32'(q);
            if (t.zero)
                r_next[i] = '0;
            else if (t.neg[i])
                r_next[i] = s32_t'(-m32);
            else
                r_next[i] = s32_t'(m32);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= dv_vld_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign out_valid = out_vld_reg;
    assign r         = r_reg;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##NORM_LAT out_valid)
        else $error("normalized beat missing");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |-> ##NORM_LAT !out_valid)
        else $error("spurious normalized beat");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && v == '0) |-> ##NORM_LAT (r == '0))
        else $error("zero vector not passed through");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (r[0] <= NORM_ONE && r[0] >= -NORM_ONE &&
                       r[1] <= NORM_ONE && r[1] >= -NORM_ONE &&
                       r[2] <= NORM_ONE && r[2] >= -NORM_ONE))
        else $error("normalized component out of range");

endmodule

// ===== sv/lav_cross.sv =====
module lav_cross (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  lav_pkg::vec32_t a,
    input  lav_pkg::vec32_t b,
    output logic            out_valid,
    output lav_pkg::vec64_t c
);
    import lav_pkg::*;

    s64_t [5:0] p_reg, p_next;
    vec64_t     c_reg, c_next;
    logic       v1_reg, v2_reg;

    always_comb
    begin
        p_next[0] = a[1] * b[2];
        p_next[1] = a[2] * b[1];
        p_next[2] = a[2] * b[0];
        p_next[3] = a[0] * b[2];
        p_next[4] = a[0] * b[1];
        p_next[5] = a[1] * b[0];
        c_next[0] = p_reg[0] - p_reg[1];
        c_next[1] = p_reg[2] - p_reg[3];
        c_next[2] = p_reg[4] - p_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        c_reg <= c_next;
    end

    assign out_valid = v2_reg;
    assign c         = c_reg;

endmodule

// ===== sv/look_at_view_matrix_unit.sv =====
// channel   handshake               payload
// command   start, busy (always 0)  cmd    : eye, target, up, Q16.16
// result    done strobe, 1 cycle    result : side, trueup, forward Q2.30; shift Q16.16
//
// One command beat per cycle; each result passes through the input register,
// three 71-stage normalize pipelines (bit-per-stage square root and division)
// and two 2-stage cross products (side first, then true up).
// Asynchronous active-low reset empties the pipeline; payload is not reset.
// The receiver cannot stall, so busy stays low and the pipeline never holds.
module look_at_view_matrix_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lav_pkg::lav_in_t cmd,
    output logic             done,
    output lav_pkg::lav_out_t result
);
    import lav_pkg::*;

    localparam int UP_DLY  = NORM_LAT + 1;
    localparam int F_DLY   = 2 * (NORM_LAT + 2);
    localparam int SD_DLY  = NORM_LAT + 2;
    localparam int EYE_DLY = TOP_LAT;

    logic   accept;
    logic   t0_vld_reg;
    vec64_t t0_raw_reg, t0_raw_next;
    vec32_t up_next, neg_next;

    vec32_t [UP_DLY-1:0]  up_pipe_reg;
    vec32_t [F_DLY-1:0]   f_pipe_reg;
    vec32_t [SD_DLY-1:0]  sd_pipe_reg;
    vec32_t [EYE_DLY-1:0] eye_pipe_reg;

    logic   fa_vld, fb_vld, fc_vld, xa_vld, xb_vld;
    vec32_t fa, fb, fc;
    vec64_t xa, xb;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        vec32_t e;
        vec32_t t;
        e = {cmd.eye_z, cmd.eye_y, cmd.eye_x};
        t = {cmd.target_z, cmd.target_y, cmd.target_x};
        up_next = {cmd.up_z, cmd.up_y, cmd.up_x};
        for (int i = 0; i < 3; i++)
        begin
            t0_raw_next[i] = 64'(e[i]) - 64'(t[i]);
            neg_next[i]    = (e[i] == S32_MIN) ? S32_MAX : s32_t'(-e[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t0_vld_reg <= 1'b0;
        else
            t0_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        t0_raw_reg   <= t0_raw_next;
        up_pipe_reg  <= {up_pipe_reg[UP_DLY-2:0], up_next};
        eye_pipe_reg <= {eye_pipe_reg[EYE_DLY-2:0], neg_next};
        f_pipe_reg   <= {f_pipe_reg[F_DLY-2:0], fa};
        sd_pipe_reg  <= {sd_pipe_reg[SD_DLY-2:0], fb};
    end

    lav_norm u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t0_vld_reg),
        .v         (t0_raw_reg),
        .out_valid (fa_vld),
        .r         (fa)
    );

    lav_cross u_cross_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fa_vld),
        .a         (up_pipe_reg[UP_DLY-1]),
        .b         (fa),
        .out_valid (xa_vld),
        .c         (xa)
    );

    lav_norm u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xa_vld),
        .v         (xa),
        .out_valid (fb_vld),
        .r         (fb)
    );

    lav_cross u_cross_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fb_vld),
        .a         (f_pipe_reg[NORM_LAT+1]),
        .b         (fb),
        .out_valid (xb_vld),
        .c         (xb)
    );

    lav_norm u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xb_vld),
        .v         (xb),
        .out_valid (fc_vld),
        .r         (fc)
    );

    always_comb
    begin
        vec32_t f;
        vec32_t s;
        vec32_t n;
        f = f_pipe_reg[F_DLY-1];
        s = sd_pipe_reg[SD_DLY-1];
        n = eye_pipe_reg[EYE_DLY-1];
        result.side_x    = s[0];
        result.side_y    = s[1];
        result.side_z    = s[2];
        result.trueup_x  = fc[0];
        result.trueup_y  = fc[1];
        result.trueup_z  = fc[2];
        result.forward_x = f[0];
        result.forward_y = f[1];
        result.forward_z = f[2];
        result.shift_x   = n[0];
        result.shift_y   = n[1];
        result.shift_z   = n[2];
    end

    assign done = fc_vld;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOP_LAT done)
        else $error("result beat missing");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##TOP_LAT !done)
        else $error("spurious result beat");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.shift_x != S32_MIN && result.shift_y != S32_MIN &&
                  result.shift_z != S32_MIN))
        else $error("shift not saturated");

endmodule

// ===== dv/look_at_view_matrix_unit_tb.sv =====
module look_at_view_matrix_unit_tb;
    import lav_pkg::*;

    localparam int OUT_FB     = 30;
    localparam int NUM_RANDOM = 1300;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    lav_in_t  cmd;
    logic     done;
    lav_out_t result;

    lav_in_t  pending_cmds[$];
    lav_out_t expected_views[$];
    int       mismatch_count;
    bit       quiet_mode;
    bit       hold_off;

    look_at_view_matrix_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic vec64_t unit_vector(vec64_t v);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] s;
        logic [63:0] len;
        logic [95:0] q;
        int          bl;
        vec64_t      r;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
            return '0;
        bl = 0;
        for (int i = 0; i < 64; i++)
            if (mx[i])
                bl = i + 1;
        for (int i = 0; i < 3; i++)
        begin
            if (bl > 31)
                m[i] = m[i] >> (bl - 31);
            else
                m[i] = m[i] << (31 - bl);
            s = s + m[i] * m[i];
        end
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((96'(m[i]) << OUT_FB) + 96'(len >> 1)) / 96'(len);
            if (q > (96'd1 << OUT_FB))
                q = 96'd1 << OUT_FB;
            r[i] = v[i] < 0 ? -s64_t'(q) : s64_t'(q);
        end
        return r;
    endfunction

    function automatic s32_t neg_sat(s32_t v);
        return v == S32_MIN ? S32_MAX : -v;
    endfunction

    function automatic lav_out_t view_matrix(lav_in_t c);
        vec64_t   raw;
        vec64_t   f;
        vec64_t   sd;
        vec64_t   tu;
        s64_t     ux;
        s64_t     uy;
        s64_t     uz;
        lav_out_t o;
        ux = c.up_x;
        uy = c.up_y;
        uz = c.up_z;
        raw[0] = s64_t'(c.eye_x) - s64_t'(c.target_x);
        raw[1] = s64_t'(c.eye_y) - s64_t'(c.target_y);
        raw[2] = s64_t'(c.eye_z) - s64_t'(c.target_z);
        f = unit_vector(raw);
        raw[0] = uy * f[2] - uz * f[1];
        raw[1] = uz * f[0] - ux * f[2];
        raw[2] = ux * f[1] - uy * f[0];
        sd = unit_vector(raw);
        raw[0] = f[1] * sd[2] - f[2] * sd[1];
        raw[1] = f[2] * sd[0] - f[0] * sd[2];
        raw[2] = f[0] * sd[1] - f[1] * sd[0];
        tu = unit_vector(raw);
        o.side_x    = s32_t'(sd[0]);
        o.side_y    = s32_t'(sd[1]);
        o.side_z    = s32_t'(sd[2]);
        o.trueup_x  = s32_t'(tu[0]);
        o.trueup_y  = s32_t'(tu[1]);
        o.trueup_z  = s32_t'(tu[2]);
        o.forward_x = s32_t'(f[0]);
        o.forward_y = s32_t'(f[1]);
        o.forward_z = s32_t'(f[2]);
        o.shift_x   = neg_sat(c.eye_x);
        o.shift_y   = neg_sat(c.eye_y);
        o.shift_z   = neg_sat(c.eye_z);
        return o;
    endfunction

    task automatic report_mismatch(string field, s32_t got, s32_t want);
        $display("%0t: %s got %0d want %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    function automatic s32_t rand_coord();
        case ($urandom_range(0, 5))
            0: return s32_t'($urandom());
            1: return s32_t'($urandom_range(0, 255)) - 128;
            2: return s32_t'($urandom_range(0, 1 << 20)) - (1 << 19);
            3: return ($urandom_range(0, 1) != 0) ? S32_MAX : S32_MIN;
            4: return s32_t'($urandom()) >>> $urandom_range(0, 31);
            default: return s32_t'($urandom_range(0, 2 << 16)) - (1 << 16);
        endcase
    endfunction

    function automatic lav_in_t make_cmd(s32_t ex, s32_t ey, s32_t ez, s32_t tx, s32_t ty,
                                         s32_t tz, s32_t ux, s32_t uy, s32_t uz);
        lav_in_t c;
        c = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_views.push_back(view_matrix(cmd));
                void'(pending_cmds.pop_front());
            end
            if (pending_cmds.size() > 0 && !hold_off
                && (quiet_mode || $urandom_range(0, 99) >= 12))
            begin
                start <= 1'b1;
                cmd   <= pending_cmds[0];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_views.size() == 0)
            begin
                report_mismatch("done", 1, 0);
            end
            else
            begin
                lav_out_t w;
                w = expected_views.pop_front();
                if (result.side_x != w.side_x) report_mismatch("side_x", result.side_x, w.side_x);
                if (result.side_y != w.side_y) report_mismatch("side_y", result.side_y, w.side_y);
                if (result.side_z != w.side_z) report_mismatch("side_z", result.side_z, w.side_z);
                if (result.trueup_x != w.trueup_x)
                    report_mismatch("trueup_x", result.trueup_x, w.trueup_x);
                if (result.trueup_y != w.trueup_y)
                    report_mismatch("trueup_y", result.trueup_y, w.trueup_y);
                if (result.trueup_z != w.trueup_z)
                    report_mismatch("trueup_z", result.trueup_z, w.trueup_z);
                if (result.forward_x != w.forward_x)
                    report_mismatch("forward_x", result.forward_x, w.forward_x);
                if (result.forward_y != w.forward_y)
                    report_mismatch("forward_y", result.forward_y, w.forward_y);
                if (result.forward_z != w.forward_z)
                    report_mismatch("forward_z", result.forward_z, w.forward_z);
                if (result.shift_x != w.shift_x)
                    report_mismatch("shift_x", result.shift_x, w.shift_x);
                if (result.shift_y != w.shift_y)
                    report_mismatch("shift_y", result.shift_y, w.shift_y);
                if (result.shift_z != w.shift_z)
                    report_mismatch("shift_z", result.shift_z, w.shift_z);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        s32_t one;
        one = 32'sh0001_0000;
        mismatch_count = 0;
        quiet_mode = 1'b0;
        hold_off   = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        pending_cmds.push_back(make_cmd(0, 0, one, 0, 0, 0, 0, one, 0));
        pending_cmds.push_back(make_cmd(one, one, one, one, one, one, 0, one, 0));
        pending_cmds.push_back(make_cmd(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX,
                                        S32_MIN, S32_MAX, S32_MIN));
        pending_cmds.push_back(make_cmd(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN,
                                        S32_MAX, S32_MIN, S32_MAX));
        pending_cmds.push_back(make_cmd(0, 0, one, 0, 0, 0, 0, 0, one));
        pending_cmds.push_back(make_cmd(0, 0, one, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(1, 0, 0, 0, 0, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(-1, -1, -1, 0, 0, 0, -1, 1, -1));
        pending_cmds.push_back(make_cmd(one, one, 0, 0, 0, 0, 0, 0, one));
        pending_cmds.push_back(make_cmd(3, 4, 0, 0, 0, 0, 0, 0, -1));
        pending_cmds.push_back(make_cmd(S32_MIN, 0, 0, 0, 0, 0, 0, S32_MIN, 0));
        pending_cmds.push_back(make_cmd(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                                        -32'sd1, -32'sd1, -32'sd1));
        pending_cmds.push_back(make_cmd(1, 1, 1, 0, 0, 0, 1, 1, 1));
        pending_cmds.push_back(make_cmd(7, 1, 2, 0, 0, 0, 1, 1, 1));
        wait (pending_cmds.size() == 0);
        hold_off <= 1'b1;
        wait (expected_views.size() == 0 && !start);
        @(posedge clk);
        hold_off <= 1'b0;

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            lav_in_t c;
            c = make_cmd(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord());
            if ($urandom_range(0, 19) == 0)
                c.target_x = c.eye_x;
            pending_cmds.push_back(c);
            if (i == NUM_RANDOM / 2)
            begin
                wait (pending_cmds.size() == 0);
                quiet_mode <= 1'b1;
            end
            if (i == NUM_RANDOM / 2 + 300)
            begin
                wait (pending_cmds.size() == 0);
                quiet_mode <= 1'b0;
            end
        end
        wait (pending_cmds.size() == 0);
        wait (expected_views.size() == 0);
        repeat (TOP_LAT + 20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
